// ===== design/wcs_pkg.sv =====
package wcs_pkg;

  localparam logic [2:0] PH_PREWASH = 3'd0;
  localparam logic [2:0] PH_WASH    = 3'd1;
  localparam logic [2:0] PH_RINSE   = 3'd2;
  localparam logic [2:0] PH_SPIN    = 3'd3;
  localparam logic [2:0] PH_DONE    = 3'd4;

  localparam logic [2:0] ST_FILL   = 3'd0;
  localparam logic [2:0] ST_AGIT   = 3'd1;
  localparam logic [2:0] ST_DRAIN  = 3'd2;
  localparam logic [2:0] ST_SPIN   = 3'd3;
  localparam logic [2:0] ST_SETTLE = 3'd4;

  // drive bit positions
  localparam int DRV_VALVE = 0;
  localparam int DRV_PUMP  = 1;
  localparam int DRV_MOTOR = 2;
  localparam int DRV_AGIT  = 3;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_START_PREWASH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_AGITATE       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SPIN_DELAY    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPIN          = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SETTLE        = 3'd4;

  typedef struct packed {
    logic        start_with_prewash;
    logic [15:0] agitate_ticks;
    logic [15:0] spin_delay_ticks;
    logic [15:0] spin_ticks;
    logic [15:0] settle_ticks;
  } cfg_t;

  typedef struct packed {
    logic action;
    logic level_reached;
    logic timer_tick;
  } item_t;

  typedef struct packed {
    logic [2:0] phase;
    logic [2:0] step;
    logic       entry_flag;
    logic [3:0] drive_levels;
  } seq_state_t;

  typedef struct packed {
    logic       water_valve;
    logic       drain_pump;
    logic       motor_cw;
    logic       agitate;
    logic [2:0] phase;
    logic [2:0] step;
    logic       done_res;
  } result_t;

endpackage

// ===== design/wcs_cfg.sv =====
module wcs_cfg
  import wcs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_with_prewash <= 1'b1;
      cfg.agitate_ticks      <= 16'd15;
      cfg.spin_delay_ticks   <= 16'd15;
      cfg.spin_ticks         <= 16'd10;
      cfg.settle_ticks       <= 16'd30;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_START_PREWASH: cfg.start_with_prewash <= cfg_data[0];
        REG_AGITATE:       cfg.agitate_ticks      <= cfg_data;
        REG_SPIN_DELAY:    cfg.spin_delay_ticks   <= cfg_data;
        REG_SPIN:          cfg.spin_ticks         <= cfg_data;
        REG_SETTLE:        cfg.settle_ticks       <= cfg_data;
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== design/wcs_step.sv =====
module wcs_step
  import wcs_pkg::*;
#(
  parameter int TIMER_WIDTH = 16
) (
  input  cfg_t                   cfg,
  input  item_t                  item,
  input  seq_state_t             cur,
  input  logic [TIMER_WIDTH-1:0] timer,
  output seq_state_t             nxt,
  output logic [TIMER_WIDTH-1:0] timer_next,
  output result_t                res
);

  localparam logic [31:0] TIMER_MAX = 32'((64'd1 << TIMER_WIDTH) - 64'd1);

  function automatic logic [TIMER_WIDTH-1:0] sat_load(input logic [15:0] ticks);
    logic [31:0] wide;
    logic [31:0] lim;
    wide = 32'(ticks);
    lim  = (wide > TIMER_MAX) ? TIMER_MAX : wide;
    return lim[TIMER_WIDTH-1:0];
  endfunction

  logic [TIMER_WIDTH-1:0] timer_dec;
  logic                   expired;

  always_comb begin
    timer_dec = (item.timer_tick && (timer != '0)) ? timer - TIMER_WIDTH'(1) : timer;
    expired   = (timer_dec == '0);
  end

  always_comb begin
    nxt        = cur;
    timer_next = timer_dec;
    if (item.action) begin
      nxt.phase        = cfg.start_with_prewash ? PH_PREWASH : PH_WASH;
      nxt.step         = ST_FILL;
      nxt.entry_flag   = 1'b1;
      nxt.drive_levels = '0;
    end else if (cur.step == ST_FILL && cur.phase <= PH_RINSE) begin
      nxt.drive_levels[DRV_VALVE] = 1'b1;
      if (cur.entry_flag) begin
        nxt.entry_flag = 1'b0;
      end else if (item.level_reached) begin
        nxt.drive_levels[DRV_VALVE] = 1'b0;
        timer_next     = sat_load(cfg.agitate_ticks);
        nxt.step       = ST_AGIT;
        nxt.entry_flag = 1'b1;
      end
    end else if (cur.step == ST_AGIT && cur.phase <= PH_RINSE) begin
      if (cur.entry_flag) begin
        nxt.drive_levels[DRV_AGIT] = 1'b1;
        nxt.entry_flag = 1'b0;
      end else if (expired) begin
        nxt.drive_levels[DRV_AGIT] = 1'b0;
        if (cur.phase == PH_PREWASH) begin
          nxt.step       = ST_FILL;
          nxt.phase      = PH_WASH;
          nxt.entry_flag = 1'b1;
        end else begin
          nxt.step = ST_DRAIN;
        end
      end
    end else if (cur.step == ST_DRAIN && (cur.phase inside {PH_WASH, PH_RINSE})) begin
      nxt.drive_levels[DRV_PUMP] = 1'b1;
      if (cur.entry_flag) begin
        nxt.entry_flag = 1'b0;
      end else if (!item.level_reached) begin
        if (cur.phase == PH_WASH) begin
          timer_next = sat_load(cfg.spin_delay_ticks);
        end else begin
          nxt.phase = PH_SPIN;
        end
        nxt.step       = ST_SPIN;
        nxt.entry_flag = 1'b1;
      end
    end else if (cur.step == ST_SPIN && (cur.phase inside {PH_WASH, PH_SPIN})) begin
      nxt.drive_levels[DRV_PUMP] = 1'b1;
      if (cur.entry_flag) begin
        if (expired) begin
          nxt.drive_levels[DRV_MOTOR] = 1'b1;
          timer_next     = sat_load(cfg.spin_ticks);
          nxt.entry_flag = 1'b0;
        end
      end else begin
        nxt.drive_levels[DRV_MOTOR] = 1'b1;
        if (expired) begin
          nxt.drive_levels[DRV_MOTOR] = 1'b0;
          timer_next = sat_load(cfg.settle_ticks);
          nxt.step   = ST_SETTLE;
        end
      end
    end else if (cur.step == ST_SETTLE && (cur.phase inside {PH_WASH, PH_SPIN})) begin
      nxt.drive_levels[DRV_PUMP]  = 1'b1;
      nxt.drive_levels[DRV_MOTOR] = 1'b0;
      if (expired) begin
        nxt.drive_levels[DRV_PUMP] = 1'b0;
        if (cur.phase == PH_WASH) begin
          nxt.step       = ST_FILL;
          nxt.phase      = PH_RINSE;
          nxt.entry_flag = 1'b1;
        end else begin
          nxt.phase = PH_DONE;
        end
      end
    end
  end

  always_comb begin
    res.water_valve = nxt.drive_levels[DRV_VALVE];
    res.drain_pump  = nxt.drive_levels[DRV_PUMP];
    res.motor_cw    = nxt.drive_levels[DRV_MOTOR];
    res.agitate     = nxt.drive_levels[DRV_AGIT];
    res.phase       = nxt.phase;
    res.step        = nxt.step;
    res.done_res    = (nxt.phase == PH_DONE);
  end

endmodule

// ===== design/washer_cycle_sequencer_unit.sv =====
// a request is captured in the input register, and the sequencer update then writes its
// result into the result register, from which it is taken
// throughput: one request per cycle unless stalled, set by the combinational sequencer update
// the input register stalls only when the result register is full and not taken
// reset: synchronous, clears both registers, sets phase done, step filling,
// timer expired, all drives off and the configuration to its defaults
module washer_cycle_sequencer_unit
  import wcs_pkg::*;
#(
  parameter int TIMER_WIDTH = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [7:0]            s_axis_tdata,  // level_reached, timer_tick, zero pad
  input  logic                  s_axis_tuser,  // action
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // water_valve, drain_pump, motor_cw, agitate, phase[3], step[3], done_res, zero pad
  output logic [15:0]           m_axis_tdata,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t                   cfg;
  logic                   in_valid;
  item_t                  in_item;
  seq_state_t             state;
  seq_state_t             state_next;
  logic [TIMER_WIDTH-1:0] timer;
  logic [TIMER_WIDTH-1:0] timer_next;
  result_t                res;
  result_t                out_res;
  logic                   out_valid;
  logic                   advance;

  wcs_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  wcs_step #(
    .TIMER_WIDTH (TIMER_WIDTH)
  ) u_step (
    .cfg        (cfg),
    .item       (in_item),
    .cur        (state),
    .timer      (timer),
    .nxt        (state_next),
    .timer_next (timer_next),
    .res        (res)
  );

  assign advance       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_item.action        <= s_axis_tuser;
      in_item.level_reached <= s_axis_tdata[0];
      in_item.timer_tick    <= s_axis_tdata[1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state.phase        <= PH_DONE;
      state.step         <= ST_FILL;
      state.entry_flag   <= 1'b1;
      state.drive_levels <= '0;
      timer              <= '0;
    end else if (advance) begin
      state <= state_next;
      timer <= timer_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= res;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {5'd0, out_res.done_res, out_res.step, out_res.phase,
                          out_res.agitate, out_res.motor_cw, out_res.drain_pump,
                          out_res.water_valve};

endmodule

// ===== dv/wcs_sequence_checker.sv =====
`timescale 1ns / 100ps

module wcs_sequence_checker
  import wcs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  input  logic                  s_axis_tready,
  input  logic [7:0]            s_axis_tdata,  // level_reached, timer_tick, zero pad
  input  logic                  s_axis_tuser,  // action
  input  logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // water_valve, drain_pump, motor_cw, agitate, phase[3], step[3], done_res, zero pad
  input  logic [15:0]           m_axis_tdata,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    pending_results,
  output int                    failures,
  output int                    results_checked,
  output int                    cycles_finished
);

  cfg_t        settings;
  seq_state_t  machine;
  logic [15:0] step_timer;
  result_t     drive_forecast[$];
  int          mismatch_count;
  int          checked_count;
  int          finished_count;

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  // one controller service call: timer first, then start or sequencer step
  task automatic service_call(input item_t call, output result_t outcome);
    logic [2:0] prior_phase;
    prior_phase = machine.phase;
    if (call.timer_tick && step_timer != '0) step_timer--;
    if (call.action) begin
      machine.phase = settings.start_with_prewash ? PH_PREWASH : PH_WASH;
      machine.step = ST_FILL;
      machine.entry_flag = 1'b1;
      machine.drive_levels = '0;
    end else begin
      case (machine.step)
        ST_FILL: if (machine.phase <= PH_RINSE) begin
          machine.drive_levels[DRV_VALVE] = 1'b1;
          if (machine.entry_flag) begin
            machine.entry_flag = 1'b0;
          end else if (call.level_reached) begin
            machine.drive_levels[DRV_VALVE] = 1'b0;
            step_timer = settings.agitate_ticks;
            machine.step = ST_AGIT;
            machine.entry_flag = 1'b1;
          end
        end
        ST_AGIT: if (machine.phase <= PH_RINSE) begin
          if (machine.entry_flag) begin
            machine.drive_levels[DRV_AGIT] = 1'b1;
            machine.entry_flag = 1'b0;
          end else if (step_timer == '0) begin
            machine.drive_levels[DRV_AGIT] = 1'b0;
            if (machine.phase == PH_PREWASH) begin
              machine.step = ST_FILL;
              machine.phase = PH_WASH;
              machine.entry_flag = 1'b1;
            end else begin
              // no entry call: draining looks at the level right away
              machine.step = ST_DRAIN;
            end
          end
        end
        ST_DRAIN: if (machine.phase == PH_WASH || machine.phase == PH_RINSE) begin
          machine.drive_levels[DRV_PUMP] = 1'b1;
          if (machine.entry_flag) begin
            machine.entry_flag = 1'b0;
          end else if (!call.level_reached) begin
            if (machine.phase == PH_WASH) begin
              step_timer = settings.spin_delay_ticks;
            end else begin
              machine.phase = PH_SPIN;
            end
            machine.step = ST_SPIN;
            machine.entry_flag = 1'b1;
          end
        end
        ST_SPIN: if (machine.phase == PH_WASH || machine.phase == PH_SPIN) begin
          machine.drive_levels[DRV_PUMP] = 1'b1;
          if (machine.entry_flag) begin
            // spin delay: wait for the timer to run out
            if (step_timer == '0) begin
              machine.drive_levels[DRV_MOTOR] = 1'b1;
              step_timer = settings.spin_ticks;
              machine.entry_flag = 1'b0;
            end
          end else begin
            machine.drive_levels[DRV_MOTOR] = 1'b1;
            if (step_timer == '0) begin
              machine.drive_levels[DRV_MOTOR] = 1'b0;
              step_timer = settings.settle_ticks;
              machine.step = ST_SETTLE;
            end
          end
        end
        ST_SETTLE: if (machine.phase == PH_WASH || machine.phase == PH_SPIN) begin
          machine.drive_levels[DRV_PUMP] = 1'b1;
          machine.drive_levels[DRV_MOTOR] = 1'b0;
          if (step_timer == '0) begin
            machine.drive_levels[DRV_PUMP] = 1'b0;
            if (machine.phase == PH_WASH) begin
              machine.step = ST_FILL;
              machine.phase = PH_RINSE;
              machine.entry_flag = 1'b1;
            end else begin
              machine.phase = PH_DONE;
            end
          end
        end
        default: ;
      endcase
    end
    if (machine.phase == PH_DONE && prior_phase != PH_DONE) finished_count++;
    outcome.water_valve = machine.drive_levels[DRV_VALVE];
    outcome.drain_pump  = machine.drive_levels[DRV_PUMP];
    outcome.motor_cw    = machine.drive_levels[DRV_MOTOR];
    outcome.agitate     = machine.drive_levels[DRV_AGIT];
    outcome.phase       = machine.phase;
    outcome.step        = machine.step;
    outcome.done_res    = machine.phase == PH_DONE;
  endtask

  always @(posedge clk) begin : watch
    item_t   call;
    result_t seen;
    result_t want;
    if (rst) begin
      settings.start_with_prewash = 1'b1;
      settings.agitate_ticks = 16'd15;
      settings.spin_delay_ticks = 16'd15;
      settings.spin_ticks = 16'd10;
      settings.settle_ticks = 16'd30;
      machine.phase = PH_DONE;
      machine.step = ST_FILL;
      machine.entry_flag = 1'b1;
      machine.drive_levels = '0;
      step_timer = '0;
      drive_forecast.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_START_PREWASH: settings.start_with_prewash = cfg_data[0];
          REG_AGITATE:       settings.agitate_ticks = cfg_data;
          REG_SPIN_DELAY:    settings.spin_delay_ticks = cfg_data;
          REG_SPIN:          settings.spin_ticks = cfg_data;
          REG_SETTLE:        settings.settle_ticks = cfg_data;
          default: ;
        endcase
      end
      if (m_axis_tvalid && m_axis_tready) begin
        seen.water_valve = m_axis_tdata[0];
        seen.drain_pump  = m_axis_tdata[1];
        seen.motor_cw    = m_axis_tdata[2];
        seen.agitate     = m_axis_tdata[3];
        seen.phase       = m_axis_tdata[6:4];
        seen.step        = m_axis_tdata[9:7];
        seen.done_res    = m_axis_tdata[10];
        if (drive_forecast.size() == 0) begin
          $error("result with no request outstanding: %h", m_axis_tdata);
          mismatch_count++;
        end else begin
          want = drive_forecast.pop_front();
          check_field("water_valve", want.water_valve, seen.water_valve);
          check_field("drain_pump", want.drain_pump, seen.drain_pump);
          check_field("motor_cw", want.motor_cw, seen.motor_cw);
          check_field("agitate", want.agitate, seen.agitate);
          check_field("phase", want.phase, seen.phase);
          check_field("step", want.step, seen.step);
          check_field("done_res", want.done_res, seen.done_res);
          check_field("pad", 0, m_axis_tdata[15:11]);
          checked_count++;
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        call.action = s_axis_tuser;
        call.level_reached = s_axis_tdata[0];
        call.timer_tick = s_axis_tdata[1];
        service_call(call, want);
        drive_forecast.push_back(want);
      end
    end
    pending_results <= drive_forecast.size();
    failures <= mismatch_count;
    results_checked <= checked_count;
    cycles_finished <= finished_count;
  end

endmodule

// ===== dv/tb_washer_cycle_sequencer_unit.sv =====
`timescale 1ns / 100ps

module tb_washer_cycle_sequencer_unit;
  import wcs_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam int DONE_BIT = 10;
  localparam int PHASE_COUNT = 12;
  localparam int CALLS_PER_PHASE = 78;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [7:0]            s_axis_tdata = '0;   // level_reached, timer_tick, zero pad
  logic                  s_axis_tuser = 1'b0; // action
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  // water_valve, drain_pump, motor_cw, agitate, phase[3], step[3], done_res, zero pad
  logic [15:0]           m_axis_tdata;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int   pending_results;
  int   failures;
  int   results_checked;
  int   cycles_finished;
  int   tx_gap_max = 0;
  int   rx_gap_max = 0;
  int   hold_requests = 0;
  int   requests_sent = 0;
  logic cycle_idle = 1'b1;

  washer_cycle_sequencer_unit i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  wcs_sequence_checker i_checker (
    .clk             (clk),
    .rst             (rst),
    .s_axis_tvalid   (s_axis_tvalid),
    .s_axis_tready   (s_axis_tready),
    .s_axis_tdata    (s_axis_tdata),
    .s_axis_tuser    (s_axis_tuser),
    .m_axis_tvalid   (m_axis_tvalid),
    .m_axis_tready   (m_axis_tready),
    .m_axis_tdata    (m_axis_tdata),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .pending_results (pending_results),
    .failures        (failures),
    .results_checked (results_checked),
    .cycles_finished (cycles_finished)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #(5_000_000);
    $display("tb: failure");
    $finish;
  end

  task automatic send_call(input logic action, input logic level, input logic tick);
    int gap;
    gap = $urandom_range(0, tx_gap_max);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {6'b0, tick, level};
    s_axis_tuser <= action;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    requests_sent++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic load_settings(input logic prewash, input logic [15:0] agit,
                               input logic [15:0] delay, input logic [15:0] spin,
                               input logic [15:0] settle);
    write_reg(REG_START_PREWASH, {15'($urandom), prewash});
    write_reg(REG_AGITATE, agit);
    write_reg(REG_SPIN_DELAY, delay);
    write_reg(REG_SPIN, spin);
    write_reg(REG_SETTLE, settle);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // result side: random stalls, plus one long hold-off on request
  initial begin : drain_results
    int wait_cycles;
    int holds_done;
    holds_done = 0;
    while (rst) @(posedge clk);
    forever begin
      if (holds_done != hold_requests) begin
        wait_cycles = 120;
        holds_done++;
      end else begin
        wait_cycles = $urandom_range(0, rx_gap_max);
      end
      if (wait_cycles != 0) begin
        m_axis_tready <= 1'b0;
        repeat (wait_cycles) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk);
      while (!m_axis_tvalid) @(posedge clk);
      cycle_idle = m_axis_tdata[DONE_BIT];
    end
  end

  initial begin : stimulus
    int   phase_no;
    int   n;
    logic start;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // walk part of one short cycle, abort it, restart
    load_settings(1'b1, 16'd1, 16'd2, 16'd1, 16'd1);
    send_call(1'b0, 1'b0, 1'b0);
    send_call(1'b0, 1'b1, 1'b1);
    send_call(1'b1, 1'b0, 1'b1);
    repeat (6) send_call(1'b0, 1'b1, 1'b1);
    repeat (12) send_call(1'b0, 1'b0, 1'b1);
    send_call(1'b1, 1'b1, 1'b0);
    send_call(1'b0, 1'b0, 1'b0);
    send_call(1'b0, 1'b1, 1'b0);
    send_call(1'b1, 1'b1, 1'b1);
    wait_idle();

    for (phase_no = 0; phase_no < PHASE_COUNT; phase_no++) begin
      case (phase_no)
        0: load_settings(1'b1, 16'd1, 16'd1, 16'd1, 16'd1);
        1: begin
          write_reg(REG_UNUSED, 16'($urandom));
          load_settings(1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        end
        2: load_settings(1'b1, 16'd15, 16'd15, 16'd10, 16'd30);
        7: load_settings(1'b1, 16'd1, 16'hFFFF, 16'd1, 16'hFFFF);
        default: load_settings(1'($urandom), 16'($urandom_range(1, 4)),
                               16'($urandom_range(1, 4)), 16'($urandom_range(1, 4)),
                               16'($urandom_range(1, 4)));
      endcase
      case (phase_no % 4)
        0: begin
          tx_gap_max = 17;
          rx_gap_max = 17;
        end
        1: begin
          tx_gap_max = 0;
          rx_gap_max = 0;
        end
        2: begin
          tx_gap_max = 0;
          rx_gap_max = 17;
        end
        default: begin
          tx_gap_max = 17;
          rx_gap_max = 0;
        end
      endcase
      if (phase_no == 6) begin
        hold_requests++;
        tx_gap_max = 0;
      end
      for (n = 0; n < CALLS_PER_PHASE; n++) begin
        start = cycle_idle ? ($urandom_range(0, 3) == 0) : ($urandom_range(0, 99) < 2);
        send_call(start, 1'($urandom), $urandom_range(0, 4) != 0);
      end
      wait_idle();
    end

    $display("summary: %0d requests sent, %0d results checked, %0d wash cycles completed",
             requests_sent, results_checked, cycles_finished);
    $display("summary: %0d setting changes incl. extremes, one long output hold-off",
             PHASE_COUNT + 1);
    if (failures == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
